// ===== rtl/core/uart_boot_image_sender_core_defines.svh =====
// assertion helpers used by the checker file
`ifndef UART_BOOT_IMAGE_SENDER_CORE_DEFINES_SVH
`define UART_BOOT_IMAGE_SENDER_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define UBIS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubis check failed");

// next-cycle implication, masked during reset
`define UBIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubis check failed");

`endif

// ===== rtl/core/ubis_pkg.sv =====
`default_nettype none
package ubis_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_RX    = 2'd1,
    CMD_IMAGE = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_STX  = 3'd1,
    PH_WAIT_ACK  = 3'd2,
    PH_SENDING   = 3'd3,
    PH_WAIT_ECHO = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_STX   = 2'd1,
    ST_NO_REPLY = 2'd2
  } status_t;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    JOB_HEADER = 2'd0,
    JOB_DATA   = 2'd1,
    JOB_DONE   = 2'd2,
    JOB_FAIL   = 2'd3
  } job_op_t;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ACK = 8'h06;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    status_t     status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    job_op_t    op;
    logic [7:0] byte_lo;
    logic [7:0] byte_hi;
    status_t    status;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/core/ubis_front.sv =====
`default_nettype none
module ubis_front import ubis_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  input  wire logic      cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic      q_full,
  output logic           push,
  output job_t           push_job
);

  phase_t      phase, phase_next;
  logic [15:0] wait_counter, wait_counter_next;
  logic [15:0] image_length, image_length_next;
  logic [15:0] bytes_sent, bytes_sent_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] timeout_limit;

  logic        accept;
  logic [7:0]  rx;
  logic [15:0] sent_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign rx       = in_item.value[7:0];
  assign sent_inc = bytes_sent + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      wait_counter <= '0;
      image_length <= '0;
      bytes_sent   <= '0;
      running_xor  <= '0;
    end else begin
      phase        <= phase_next;
      wait_counter <= wait_counter_next;
      image_length <= image_length_next;
      bytes_sent   <= bytes_sent_next;
      running_xor  <= running_xor_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    wait_counter_next = wait_counter;
    image_length_next = image_length;
    bytes_sent_next   = bytes_sent;
    running_xor_next  = running_xor;
    push              = 1'b0;
    push_job          = '{op: JOB_DATA, byte_lo: 8'h00, byte_hi: 8'h00, status: ST_OK};
    if (accept) begin
      case (in_item.cmd)
        CMD_START: begin
          // restart from scratch, any load in progress is dropped silently
          image_length_next = in_item.value;
          bytes_sent_next   = '0;
          running_xor_next  = '0;
          wait_counter_next = '0;
          phase_next        = PH_WAIT_STX;
        end
        CMD_RX: begin
          if (phase == PH_WAIT_STX && rx == BYTE_STX) begin
            push              = 1'b1;
            push_job.op       = JOB_HEADER;
            push_job.byte_lo  = image_length[7:0];
            push_job.byte_hi  = image_length[15:8];
            wait_counter_next = '0;
            phase_next        = PH_WAIT_ACK;
          end else if (phase == PH_WAIT_ACK && rx == BYTE_ACK) begin
            if (image_length == 16'd0) begin
              wait_counter_next = '0;
              phase_next        = PH_WAIT_ECHO;
            end else begin
              phase_next = PH_SENDING;
            end
          end else if (phase == PH_WAIT_ECHO && rx == running_xor) begin
            push        = 1'b1;
            push_job.op = JOB_DONE;
            phase_next  = PH_IDLE;
          end
        end
        CMD_IMAGE: begin
          if (phase == PH_SENDING) begin
            push             = 1'b1;
            push_job.op      = JOB_DATA;
            push_job.byte_lo = rx;
            running_xor_next = running_xor ^ rx;
            bytes_sent_next  = sent_inc;
            if (sent_inc == image_length) begin
              wait_counter_next = '0;
              phase_next        = PH_WAIT_ECHO;
            end
          end
        end
        CMD_TICK: begin
          if (phase == PH_WAIT_STX || phase == PH_WAIT_ACK || phase == PH_WAIT_ECHO) begin
            if (wait_counter >= timeout_limit) begin
              push            = 1'b1;
              push_job.op     = JOB_FAIL;
              push_job.status = (phase == PH_WAIT_STX) ? ST_NO_STX : ST_NO_REPLY;
              phase_next      = PH_IDLE;
            end else begin
              wait_counter_next = wait_counter + 16'd1;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ubis_queue.sv =====
`default_nettype none
module ubis_queue import ubis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      not_empty
);

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ubis_back.sv =====
`default_nettype none
module ubis_back import ubis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic not_empty,
  input  wire job_t pop_data,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_item
);

  job_t       job;
  logic       job_valid;
  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       out_xfer;
  logic       at_last;

  assign out_valid = job_valid;
  assign out_xfer  = job_valid && !out_stall;
  assign at_last   = (idx == last_idx);
  // refill when no job is held, or as soon as the current job has nothing left after this transfer
  assign pop       = not_empty && (!job_valid || (out_xfer && at_last));

  always_comb begin
    out_item = '{kind: KIND_TX, tx_byte: 8'h00, status: ST_OK, last: 1'b0};
    last_idx = 2'd0;
    case (job.op)
      JOB_HEADER: begin
        last_idx = 2'd2;
        case (idx)
          2'd0:    out_item.tx_byte = BYTE_SOH;
          2'd1:    out_item.tx_byte = job.byte_lo;
          default: out_item.tx_byte = job.byte_hi;
        endcase
      end
      JOB_DATA: begin
        out_item.tx_byte = job.byte_lo;
      end
      JOB_DONE: begin
        last_idx = 2'd1;
        if (idx == 2'd0) begin
          out_item.tx_byte = BYTE_ACK;
        end else begin
          out_item.kind = KIND_REPORT;
        end
      end
      default: begin
        out_item.kind   = KIND_REPORT;
        out_item.status = job.status;
      end
    endcase
    out_item.last = (idx == last_idx);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (out_xfer) begin
      if (at_last) begin
        job_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/uart_boot_image_sender_core.sv =====
// path: an item that makes a job is pushed into the job queue, then loaded into the
//   back's job register, from which its first result is offered; a stall can hold it
// throughput: one input item per cycle while the 4-entry job queue has room,
//   one result per cycle out while out_stall is low; a job holds up to three results
// reset (rst, synchronous): phase to idle, counters and checksum cleared,
//   timeout_limit back to 100, job queue and output emptied
`default_nettype none
module uart_boot_image_sender_core import ubis_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  job_t pop_data;
  logic not_empty;

  ubis_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  ubis_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  ubis_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== rtl/core/ubis_checker.sv =====
`default_nettype none
`include "uart_boot_image_sender_core_defines.svh"
module ubis_checker import ubis_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  `UBIS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `UBIS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_item))
  // a report always closes the results of its item and carries no byte
  `UBIS_ASSERT_SAME(a_report_last, clk, rst, out_valid && out_item.kind == KIND_REPORT, out_item.last && out_item.tx_byte == 8'h00)
  `UBIS_ASSERT_SAME(a_tx_status, clk, rst, out_valid && out_item.kind == KIND_TX, out_item.status == ST_OK)

endmodule

bind uart_boot_image_sender_core ubis_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
